// File: rtl/mmt_pkg.sv
// shared types and constants of the multiset mex tracker
// no dependencies; imported by every module of the block
package mmt_pkg;

  localparam int unsigned VALUE_W    = 16;
  localparam int unsigned VALUE_SPAN = 65536;
  localparam int unsigned MEX_W      = 11;
  localparam int unsigned MEXF_W     = 17;
  localparam int unsigned STATUS_W   = 2;
  localparam int unsigned ROW_BITS   = 32;
  localparam int unsigned ROW_SEL_W  = 5;

  localparam logic [STATUS_W-1:0] STATUS_OK     = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_RANGE  = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_ABSENT = 2'd2;
  localparam logic [STATUS_W-1:0] STATUS_SAT    = 2'd3;

  // controller to datapath
  typedef struct packed {
    logic clear;
    logic accept;
    logic update;
    logic load_out;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic clear_last;
  } sts_t;

endpackage

// File: rtl/mmt_ctrl.sv
// sequencer of the multiset mex tracker: clear pass, accept, update, result
// depends on mmt_pkg
module mmt_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output mmt_pkg::cmd_t cmd_o,
  input  mmt_pkg::sts_t sts_i
);
  import mmt_pkg::*;

  typedef enum logic [3:0] {
    ST_CLEAR  = 4'b0001,
    ST_IDLE   = 4'b0010,
    ST_UPDATE = 4'b0100,
    ST_RESULT = 4'b1000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free, can_accept, accept;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign can_accept = (state_q == ST_IDLE) || ((state_q == ST_RESULT) && out_free);
  assign accept     = in_valid_i && can_accept;

  assign in_stall_o  = !can_accept;
  assign out_valid_o = out_valid_q;

  assign cmd_o.clear    = (state_q == ST_CLEAR);
  assign cmd_o.accept   = accept;
  assign cmd_o.update   = (state_q == ST_UPDATE);
  assign cmd_o.load_out = (state_q == ST_RESULT) && out_free;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: begin
        if (sts_i.clear_last) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (accept) state_d = ST_UPDATE;
      end
      ST_UPDATE: begin
        state_d = ST_RESULT;
      end
      ST_RESULT: begin
        if (out_free) state_d = accept ? ST_UPDATE : ST_IDLE;
      end
      default: begin
        state_d = ST_CLEAR;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.load_out) out_valid_d = 1'b1;
    else if (!out_stall_i) out_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

// File: rtl/mmt_dp.sv
// datapath of the multiset mex tracker: count and bitmap memories, row summary,
// find-first logic and result register; depends on mmt_pkg
module mmt_dp #(
  parameter int unsigned VALUES     = 1024,
  parameter int unsigned COUNT_BITS = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  mmt_pkg::cmd_t                  cmd_i,
  output mmt_pkg::sts_t                  sts_o,
  input  logic                           command_i,
  input  logic [mmt_pkg::VALUE_W-1:0]    value_i,
  output logic [mmt_pkg::MEX_W-1:0]      mex_o,
  output logic [mmt_pkg::STATUS_W-1:0]   status_o
);
  import mmt_pkg::*;

  // values above the input span can never be present
  localparam int unsigned STORE  = (VALUES < VALUE_SPAN) ? VALUES : VALUE_SPAN;
  localparam int unsigned IDX_W  = (STORE > 1) ? $clog2(STORE) : 1;
  localparam int unsigned ROWS   = (STORE + ROW_BITS - 1) / ROW_BITS;
  localparam int unsigned RIDX_W = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;
  localparam logic [COUNT_BITS-1:0] CNT_ONE = COUNT_BITS'(1);

  function automatic logic [ROW_BITS-1:0] row_init(input logic [RIDX_W-1:0] row);
    logic [ROW_BITS-1:0] w;
    for (int j = 0; j < ROW_BITS; j++) begin
      w[j] = ((32'(row) * 32'(ROW_BITS) + 32'(j)) < 32'(STORE));
    end
    return w;
  endfunction

  logic [COUNT_BITS-1:0] cnt_mem [STORE];
  logic [ROW_BITS-1:0]   row_mem [ROWS];

  logic                  cmd_q;
  logic [VALUE_W-1:0]    value_q;
  logic [COUNT_BITS-1:0] cnt_rd_q;
  logic [ROW_BITS-1:0]   row_rd_q;
  logic [IDX_W-1:0]      clr_q;
  logic [ROWS-1:0]       summary_q;
  logic [RIDX_W-1:0]     found_row_q;
  logic                  found_any_q;
  logic                  fwd_q;
  logic [ROW_BITS-1:0]   new_row_q;
  logic [STATUS_W-1:0]   st_q;
  logic [MEX_W-1:0]      mex_q;
  logic [STATUS_W-1:0]   status_q;

  logic [IDX_W-1:0]      acc_idx, upd_idx;
  logic [RIDX_W-1:0]     acc_row, upd_row, clr_row;
  logic [ROW_SEL_W-1:0]  upd_bit;
  logic                  in_range, write_en, new_bit;
  logic [STATUS_W-1:0]   st;
  logic [COUNT_BITS-1:0] cnt_new;
  logic [ROW_BITS-1:0]   new_row;
  logic [ROWS-1:0]       excl_mask;
  logic                  excl_any, found_any;
  logic [RIDX_W-1:0]     excl_row, found_row;
  logic [ROW_BITS-1:0]   res_word;
  logic [ROW_SEL_W-1:0]  res_bit;
  logic [MEXF_W-1:0]     mex_full;

  assign acc_idx = value_i[IDX_W-1:0];
  assign acc_row = RIDX_W'(value_i >> ROW_SEL_W);
  assign upd_idx = value_q[IDX_W-1:0];
  assign upd_row = RIDX_W'(value_q >> ROW_SEL_W);
  assign upd_bit = value_q[ROW_SEL_W-1:0];
  assign clr_row = RIDX_W'(clr_q >> ROW_SEL_W);

  assign sts_o.clear_last = (clr_q == IDX_W'(STORE - 1));

  // count update and status
  assign in_range = (32'(value_q) < 32'(VALUES));
  assign cnt_new  = cmd_q ? (cnt_rd_q - CNT_ONE) : (cnt_rd_q + CNT_ONE);
  assign new_bit  = cmd_q ? (cnt_rd_q == CNT_ONE) : 1'b0;

  always_comb begin
    if (!in_range) st = STATUS_RANGE;
    else if (!cmd_q && (cnt_rd_q == CNT_MAX)) st = STATUS_SAT;
    else if (cmd_q && (cnt_rd_q == '0)) st = STATUS_ABSENT;
    else st = STATUS_OK;
  end

  assign write_en = cmd_i.update && (st == STATUS_OK);

  always_comb begin
    new_row = row_rd_q;
    if (st == STATUS_OK) new_row[upd_bit] = new_bit;
  end

  // first non-empty row, leaving out the row being updated when the value is in range
  always_comb begin
    excl_mask = summary_q;
    if (in_range) excl_mask[upd_row] = 1'b0;
  end

  always_comb begin
    excl_any = 1'b0;
    excl_row = '0;
    for (int i = ROWS - 1; i >= 0; i--) begin
      if (excl_mask[i]) begin
        excl_any = 1'b1;
        excl_row = RIDX_W'(i);
      end
    end
  end

  always_comb begin
    if (in_range && (|new_row) && (!excl_any || (upd_row < excl_row))) begin
      found_any = 1'b1;
      found_row = upd_row;
    end else begin
      found_any = excl_any;
      found_row = excl_row;
    end
  end

  // memories: one write and one read port each
  always_ff @(posedge clk_i) begin
    if (cmd_i.clear) begin
      cnt_mem[clr_q]   <= '0;
      row_mem[clr_row] <= row_init(clr_row);
    end else if (write_en) begin
      cnt_mem[upd_idx] <= cnt_new;
      row_mem[upd_row] <= new_row;
    end
    if (cmd_i.accept) begin
      cnt_rd_q <= cnt_mem[acc_idx];
      row_rd_q <= row_mem[acc_row];
    end else if (cmd_i.update) begin
      row_rd_q <= row_mem[found_row];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q     <= '0;
      summary_q <= '1;
    end else begin
      if (cmd_i.clear) clr_q <= clr_q + IDX_W'(1);
      if (write_en) summary_q[upd_row] <= |new_row;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      cmd_q   <= command_i;
      value_q <= value_i;
    end
    if (cmd_i.update) begin
      found_row_q <= found_row;
      found_any_q <= found_any;
      fwd_q       <= write_en && (found_row == upd_row);
      new_row_q   <= new_row;
      st_q        <= st;
    end
    if (cmd_i.load_out) begin
      mex_q    <= mex_full[MEX_W-1:0];
      status_q <= st_q;
    end
  end

  // bit within the chosen row
  assign res_word = fwd_q ? new_row_q : row_rd_q;

  always_comb begin
    res_bit = '0;
    for (int k = ROW_BITS - 1; k >= 0; k--) begin
      if (res_word[k]) res_bit = ROW_SEL_W'(k);
    end
  end

  assign mex_full = found_any_q
                  ? ((MEXF_W'(found_row_q) << ROW_SEL_W) | MEXF_W'(res_bit))
                  : MEXF_W'(STORE);

  assign mex_o    = mex_q;
  assign status_o = status_q;

endmodule

// File: rtl/multiset_mex_tracker.sv
// top level of the multiset mex tracker: controller plus datapath
// depends on mmt_pkg, mmt_ctrl and mmt_dp
//
//   channel   direction   handshake                 payload
//   in        to block    in_valid_i / in_stall_o   command_i, value_i
//   out       from block  out_valid_o / out_stall_i mex_o, status_o
//
// a word is handled in an accept step reading the count and bitmap row, then an
//   update step writing them back and reading the row with the smallest absent
//   value; with the single read port of the bitmap row memory, the next word is
//   accepted in the result state at the earliest, once the output is free
// after reset a clearing pass over min(VALUES, 65536) count entries (1024 by
//   default) writes every count and bitmap row before the first word is accepted
// a stalled output holds its word; the next word is still accepted and waits
//   in the result state until the output register frees
module multiset_mex_tracker #(
  parameter int unsigned VALUES     = 1024,
  parameter int unsigned COUNT_BITS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          command_i,
  input  logic [mmt_pkg::VALUE_W-1:0]   value_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [mmt_pkg::MEX_W-1:0]     mex_o,
  output logic [mmt_pkg::STATUS_W-1:0]  status_o
);
  import mmt_pkg::*;

  // command and status bundles between sequencer and datapath
  cmd_t cmd;
  sts_t sts;

  // sequencer: clear pass, handshakes, output valid
  mmt_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  // datapath: counts, absent bitmap, row summary and find-first
  mmt_dp #(
    .VALUES     (VALUES),
    .COUNT_BITS (COUNT_BITS)
  ) u_dp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (cmd),
    .sts_o     (sts),
    .command_i (command_i),
    .value_i   (value_i),
    .mex_o     (mex_o),
    .status_o  (status_o)
  );

endmodule

// File: rtl/mmt_checker.sv
// port-level checks of the multiset mex tracker, bound to the top level
// depends on mmt_pkg and multiset_mex_tracker
module mmt_checker #(
  parameter int unsigned VALUES = 1024
) (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_stall_o,
  input logic                          out_valid_o,
  input logic                          out_stall_i,
  input logic [mmt_pkg::MEX_W-1:0]     mex_o,
  input logic [mmt_pkg::STATUS_W-1:0]  status_o
);
  import mmt_pkg::*;

  logic       in_fire, out_fire;
  logic [1:0] pend_q;

  assign in_fire  = in_valid_i && !in_stall_o;
  assign out_fire = out_valid_o && !out_stall_i;

  // words accepted and not yet delivered
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= 2'd0;
    end else if (in_fire && !out_fire) begin
      pend_q <= pend_q + 2'd1;
    end else if (out_fire && !in_fire) begin
      pend_q <= pend_q - 2'd1;
    end
  end

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(mex_o) && $stable(status_o))
    else $error("stalled result word changed");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> in_stall_o)
    else $error("word accepted in the cycle after an accept");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (pend_q != 2'd0) && (pend_q != 2'd3))
    else $error("result word without a matching input word");

  a_mex_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (VALUES >= 2048) || (32'(mex_o) <= 32'(VALUES)))
    else $error("mex beyond the value range");

endmodule

bind multiset_mex_tracker mmt_checker #(
  .VALUES (VALUES)
) u_mmt_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .mex_o       (mex_o),
  .status_o    (status_o)
);

// File: bench/tb_top.sv
`timescale 1ns / 100ps
// regression bench for multiset_mex_tracker: directed table, random words and
// a closing back-to-back run; pinned directed rows are scored against their
// hand-written results, all other words against a local predictor; depends on mmt_pkg and multiset_mex_tracker
module tb_top;

  import mmt_pkg::*;

  localparam int unsigned VALUES       = 1024;
  localparam int unsigned COUNT_BITS   = 16;
  localparam int unsigned HALF_PERIOD  = 5;
  localparam int unsigned RANDOM_WORDS = 800;
  localparam int unsigned TAIL_WORDS   = 30;
  localparam int unsigned SHOW_LIMIT   = 10;
  localparam int unsigned DIR_N        = 23;

  localparam logic CMD_ADD    = 1'b0;
  localparam logic CMD_REMOVE = 1'b1;

  localparam logic [COUNT_BITS-1:0] COUNT_TOP = '1;

  // one result word as the block returns it
  typedef struct packed {
    logic [MEX_W-1:0]    mex;
    logic [STATUS_W-1:0] status;
  } mex_word_t;

  // directed row; pinned rows carry a hand-written result
  typedef struct packed {
    logic            cmd;
    logic [VALUE_W-1:0] val;
    logic            pinned;
    mex_word_t       pin;
  } dir_row_t;

  localparam dir_row_t DIR_ROWS [DIR_N] = '{
    // straight after reset: nothing present, mex is zero
    '{CMD_REMOVE, 16'h0000, 1'b1, '{11'd0, STATUS_ABSENT}},
    '{CMD_ADD,    16'hFFFF, 1'b1, '{11'd0, STATUS_RANGE}},
    '{CMD_REMOVE, 16'hFFFF, 1'b1, '{11'd0, STATUS_RANGE}},
    '{CMD_ADD,    16'd1024, 1'b1, '{11'd0, STATUS_RANGE}},
    '{CMD_ADD,    16'd1023, 1'b1, '{11'd0, STATUS_OK}},
    '{CMD_ADD,    16'd0,    1'b1, '{11'd1, STATUS_OK}},
    '{CMD_ADD,    16'd1,    1'b1, '{11'd2, STATUS_OK}},
    // from here on the predictor scores the rows
    '{CMD_ADD,    16'd0,    1'b0, '{11'd0, STATUS_OK}},
    '{CMD_REMOVE, 16'd0,    1'b0, '{11'd0, STATUS_OK}},
    '{CMD_REMOVE, 16'd0,    1'b0, '{11'd0, STATUS_OK}},
    '{CMD_REMOVE, 16'd0,    1'b0, '{11'd0, STATUS_OK}},
    '{CMD_ADD,    16'd0,    1'b0, '{11'd0, STATUS_OK}},
    '{CMD_ADD,    16'd2,    1'b0, '{11'd0, STATUS_OK}},
    '{CMD_REMOVE, 16'd1,    1'b0, '{11'd0, STATUS_OK}},
    '{CMD_REMOVE, 16'd1023, 1'b0, '{11'd0, STATUS_OK}},
    '{CMD_REMOVE, 16'd1023, 1'b0, '{11'd0, STATUS_OK}},
    '{CMD_ADD,    16'h8000, 1'b0, '{11'd0, STATUS_OK}},
    '{CMD_REMOVE, 16'h5555, 1'b0, '{11'd0, STATUS_OK}},
    '{CMD_ADD,    16'hAAAA, 1'b0, '{11'd0, STATUS_OK}},
    '{CMD_ADD,    16'h0155, 1'b0, '{11'd0, STATUS_OK}},
    '{CMD_ADD,    16'h02AA, 1'b0, '{11'd0, STATUS_OK}},
    '{CMD_REMOVE, 16'h02AA, 1'b0, '{11'd0, STATUS_OK}},
    '{CMD_ADD,    16'd1,    1'b0, '{11'd0, STATUS_OK}}
  };

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_stall_o;
  logic               command_i;
  logic [VALUE_W-1:0] value_i;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic [MEX_W-1:0]   mex_o;
  logic [STATUS_W-1:0] status_o;

  // predictor state: occurrence tallies, absent flags and the running mex
  logic [COUNT_BITS-1:0] tally [VALUES];
  logic                  absent_map [VALUES];
  int unsigned           mex_now;

  // results still owed by the block, oldest first
  mex_word_t mex_due [$];

  logic        gaps_on = 1'b1;
  int unsigned stall_left = 0;
  int unsigned fault_count = 0;
  int unsigned word_count = 0;
  int unsigned range_seen = 0;
  int unsigned absent_seen = 0;
  int unsigned sat_seen = 0;
  int unsigned full_seen = 0;
  int unsigned mex_peak = 0;

  multiset_mex_tracker #(
    .VALUES     (VALUES),
    .COUNT_BITS (COUNT_BITS)
  ) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .command_i   (command_i),
    .value_i     (value_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .mex_o       (mex_o),
    .status_o    (status_o)
  );

  initial clk_i = 1'b0;
  always #(HALF_PERIOD) clk_i = ~clk_i;

  // applies one word to the predicted multiset and returns the mex that follows
  function automatic mex_word_t track_word(input logic cmd, input logic [VALUE_W-1:0] val);
    mex_word_t   res;
    int unsigned v;
    res.status = STATUS_OK;
    v = 32'(val);
    if (v >= VALUES) begin
      res.status = STATUS_RANGE;
    end else if (cmd == CMD_ADD) begin
      if (tally[v] == COUNT_TOP) begin
        res.status = STATUS_SAT;
      end else begin
        tally[v] = tally[v] + 1'b1;
        absent_map[v] = 1'b0;
      end
    end else if (tally[v] == '0) begin
      res.status = STATUS_ABSENT;
    end else begin
      tally[v] = tally[v] - 1'b1;
      if (tally[v] == '0) absent_map[v] = 1'b1;
    end
    // a value that just went absent below the mex pulls it down
    if (res.status == STATUS_OK && absent_map[v] && v < mex_now) mex_now = v;
    // otherwise walk upwards past everything present
    while (mex_now < VALUES && !absent_map[mex_now]) mex_now++;
    res.mex = MEX_W'(mex_now);
    return res;
  endfunction

  task automatic log_fault(input string what, input mex_word_t want, input mex_word_t got);
    fault_count++;
    if (fault_count <= SHOW_LIMIT) begin
      $display("%0t: %s: expected mex %0d status %0d, got mex %0d status %0d",
               $realtime, what, want.mex, want.status, got.mex, got.status);
    end
  endtask

  // offers one word, waits for the handshake, then books its result
  task automatic send_word(input logic cmd, input logic [VALUE_W-1:0] val,
                           input logic pinned, input mex_word_t pin);
    mex_word_t guess;
    // random gap on the sending side
    if (gaps_on && $urandom_range(0, 4) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    command_i  <= cmd;
    value_i    <= val;
    do @(posedge clk_i); while (in_stall_o);
    guess = track_word(cmd, val);
    mex_due.push_back(pinned ? pin : guess);
    word_count++;
    case (guess.status)
      STATUS_RANGE:  range_seen++;
      STATUS_ABSENT: absent_seen++;
      STATUS_SAT:    sat_seen++;
      default: ;
    endcase
    if (guess.mex == MEX_W'(VALUES)) full_seen++;
    if (32'(guess.mex) > mex_peak) mex_peak = 32'(guess.mex);
  endtask

  // holds the sender back until the block owes nothing
  task automatic drain_results();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (mex_due.size() != 0);
  endtask

  // receiver: random stall bursts while gaps are on
  always @(posedge clk_i) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
    end else if (gaps_on && $urandom_range(0, 5) == 0) begin
      out_stall_i <= 1'b1;
      stall_left  <= $urandom_range(0, 7);
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  // scoreboard: every taken result against the oldest booked one
  always @(posedge clk_i) begin
    mex_word_t want;
    mex_word_t got;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got.mex    = mex_o;
      got.status = status_o;
      if (mex_due.size() == 0) begin
        log_fault("result with nothing outstanding", '0, got);
      end else begin
        want = mex_due.pop_front();
        if (got.mex !== want.mex || got.status !== want.status) begin
          log_fault("result mismatch", want, got);
        end
      end
    end
  end

  // stimulus
  initial begin
    int unsigned   pick;
    int unsigned   top;
    logic          cmd;
    logic [VALUE_W-1:0] val;

    rst_ni     = 1'b0;
    in_valid_i = 1'b0;
    command_i  = CMD_ADD;
    value_i    = '0;
    foreach (tally[i]) begin
      tally[i]      = '0;
      absent_map[i] = 1'b1;
    end
    mex_now = 0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    // the block runs its clearing pass behind a stalled input, so just offer

    // directed table
    for (int r = 0; r < DIR_N; r++) begin
      send_word(DIR_ROWS[r].cmd, DIR_ROWS[r].val, DIR_ROWS[r].pinned, DIR_ROWS[r].pin);
    end

    // random words, mostly around the current mex so it climbs and falls
    for (int n = 0; n < RANDOM_WORDS; n++) begin
      if (n % 100 == 0) gaps_on <= ($urandom_range(0, 3) != 0);
      pick = $urandom_range(0, 99);
      top  = (mex_now + 8 > VALUES - 1) ? VALUES - 1 : mex_now + 8;
      if (pick < 55) begin
        val = VALUE_W'($urandom_range(0, top));
        cmd = ($urandom_range(0, 99) < 62) ? CMD_ADD : CMD_REMOVE;
      end else if (pick < 70) begin
        // removals just above the mex often hit absent values
        val = VALUE_W'($urandom_range(mex_now < VALUES ? mex_now : VALUES - 1, top));
        cmd = CMD_REMOVE;
      end else if (pick < 85) begin
        val = VALUE_W'($urandom_range(0, VALUES - 1));
        cmd = $urandom_range(0, 1) ? CMD_REMOVE : CMD_ADD;
      end else begin
        val = VALUE_W'($urandom_range(VALUES, 65535));
        cmd = $urandom_range(0, 1) ? CMD_REMOVE : CMD_ADD;
      end
      send_word(cmd, val, 1'b0, '0);
    end

    // sender holds off until the block has caught up
    drain_results();

    // last part, no gaps: back-to-back words at the mex; adds push it up, removes at the mex mostly find it absent
    gaps_on <= 1'b0;
    repeat (10) @(posedge clk_i);
    for (int n = 0; n < TAIL_WORDS; n++) begin
      top = (mex_now < VALUES) ? mex_now : VALUES - 1;
      cmd = (n % 3 == 2) ? CMD_REMOVE : CMD_ADD;
      send_word(cmd, VALUE_W'(top), 1'b0, '0);
    end

    // wind down, then allow time for anything stray
    drain_results();
    repeat (16) @(posedge clk_i);

    $display("%0d words: %0d out of range, %0d removes of absent values, %0d saturated adds",
             word_count, range_seen, absent_seen, sat_seen);
    $display("mex peaked at %0d, every value present on %0d words, %0d mismatches",
             mex_peak, full_seen, fault_count);
    if (fault_count == 0) begin
      $display("multiset_mex_tracker regression: pass");
    end else begin
      $display("multiset_mex_tracker regression: fail");
    end
    $finish;
  end

  // watchdog, well beyond the slowest legal run
  initial begin
    #10_000_000;
    $display("multiset_mex_tracker regression: fail");
    $finish;
  end

endmodule

// File: multiset_mex_tracker.f
rtl/mmt_pkg.sv
rtl/mmt_ctrl.sv
rtl/mmt_dp.sv
rtl/multiset_mex_tracker.sv
rtl/mmt_checker.sv
bench/tb_top.sv
